// File: rtl/olte_pkg.sv
// Shared types and constants for the ordered list table engine.
package olte_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ST_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_GET     = 3'd0,
        OP_SET     = 3'd1,
        OP_INSERT  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_PUSH    = 3'd4,
        OP_POP     = 3'd5,
        OP_FIND    = 3'd6,
        OP_REMOVE  = 3'd7
    } t_op;

    localparam logic [ST_W-1:0] STS_OK    = 2'd0;
    localparam logic [ST_W-1:0] STS_RANGE = 2'd1;
    localparam logic [ST_W-1:0] STS_FULL  = 2'd2;
    localparam logic [ST_W-1:0] STS_EMPTY = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch the input transfer
        logic check;  // range checks, single writes, pointer setup
        logic rd;     // issue a memory read
        logic wr;     // consume read data, advance pointer
        logic fin;    // commit count, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;
        logic loop;
        logic more;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/olte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olte_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/olte_ctrl.sv
// Sequencer for the list engine: check, read/write sweep, commit.
module olte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  olte_pkg::t_sts i_sts,
    output olte_pkg::t_cmd o_cmd
);
    import olte_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_RD, S_WR, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = (i_sts.err || !i_sts.loop) ? S_FIN : S_RD;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = i_sts.more ? S_RD : S_FIN;
            S_FIN:   if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.check = (r_state == S_CHECK);
    assign o_cmd.rd    = (r_state == S_RD);
    assign o_cmd.wr    = (r_state == S_WR);
    assign o_cmd.fin   = (r_state == S_FIN) && !i_sts.out_busy;
endmodule

// File: rtl/olte_dp.sv
// Datapath: list memory, count, sweep pointers and result register.
module olte_dp #(
    parameter int CAPACITY = olte_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  olte_pkg::t_cmd               i_cmd,
    output olte_pkg::t_sts               o_sts,
    input  logic [olte_pkg::OP_W-1:0]    i_op,
    input  logic [olte_pkg::IDX_W-1:0]   i_index,
    input  logic signed [olte_pkg::DATA_W-1:0] i_value,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic signed [olte_pkg::DATA_W-1:0] o_read_value,
    output logic                         o_found,
    output logic [olte_pkg::IDX_W-1:0]   o_found_index,
    output logic [olte_pkg::CNT_W-1:0]   o_removed_count,
    output logic [olte_pkg::ST_W-1:0]    o_status,
    output logic [olte_pkg::CNT_W-1:0]   o_element_count
);
    import olte_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > CNT_W) ? CW : CNT_W;

    t_op                r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [DATA_W-1:0]  r_val;
    logic [CW-1:0]      r_cnt, r_ptr, r_wp;
    logic [DATA_W-1:0]  r_rd;
    logic               r_found;
    logic [CW-1:0]      r_fidx;
    logic [ST_W-1:0]    r_st;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_o_rd;
    logic               r_o_found;
    logic [IDX_W-1:0]   r_o_fidx;
    logic [CNT_W-1:0]   r_o_rem, r_o_cnt;
    logic [ST_W-1:0]    r_o_st;

    logic [IW-1:0]      idx_w, cnt_w, fidx_w, rem_w, ncnt_w;
    logic [CW-1:0]      ptr_nx, cnt_nx, rem;
    logic               full, err, loop, more, eq;
    logic [ST_W-1:0]    st_chk;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [DATA_W-1:0]  wdata, rdata;

    assign idx_w = IW'(r_idx);
    assign cnt_w = IW'(r_cnt);
    assign full  = (cnt_w == IW'(CAPACITY));
    assign eq    = (rdata == r_val);

    always_comb begin
        st_chk = STS_OK;
        loop   = 1'b0;
        case (r_op)
            OP_GET: begin
                if (idx_w >= cnt_w) st_chk = STS_RANGE;
                loop = 1'b1;
            end
            OP_SET: if (idx_w >= cnt_w) st_chk = STS_RANGE;
            OP_INSERT: begin
                if (full) st_chk = STS_FULL;
                else if (idx_w > cnt_w) st_chk = STS_RANGE;
                loop = (idx_w != cnt_w);
            end
            OP_DELETE: begin
                if (idx_w >= cnt_w) st_chk = STS_RANGE;
                loop = ((idx_w + IW'(1)) < cnt_w);
            end
            OP_PUSH: if (full) st_chk = STS_FULL;
            OP_POP: begin
                if (r_cnt == '0) st_chk = STS_EMPTY;
                loop = 1'b1;
            end
            OP_FIND, OP_REMOVE: loop = (r_cnt != '0);
            default: loop = 1'b0;
        endcase
    end
    assign err = (st_chk != STS_OK);

    // next pointer and sweep continuation
    always_comb begin
        ptr_nx = r_ptr + CW'(1);
        more   = 1'b0;
        case (r_op)
            OP_INSERT: begin
                ptr_nx = r_ptr - CW'(1);
                more   = (IW'(ptr_nx) > idx_w);
            end
            OP_DELETE:  more = ((IW'(ptr_nx) + IW'(1)) < cnt_w);
            OP_FIND:    more = !eq && (ptr_nx < r_cnt);
            OP_REMOVE:  more = (ptr_nx < r_cnt);
            default:    more = 1'b0;
        endcase
    end

    // read address
    always_comb begin
        case (r_op)
            OP_INSERT: raddr = AW'(r_ptr - CW'(1));
            OP_DELETE: raddr = AW'(r_ptr + CW'(1));
            default:   raddr = r_ptr[AW-1:0];
        endcase
    end

    // write port
    always_comb begin
        we    = 1'b0;
        waddr = r_ptr[AW-1:0];
        wdata = rdata;
        if (i_cmd.check && !err && r_op == OP_SET) begin
            we = 1'b1; waddr = idx_w[AW-1:0]; wdata = r_val;
        end else if (i_cmd.check && !err && r_op == OP_PUSH) begin
            we = 1'b1; waddr = r_cnt[AW-1:0]; wdata = r_val;
        end else if (i_cmd.wr && (r_op == OP_INSERT || r_op == OP_DELETE)) begin
            we = 1'b1;
        end else if (i_cmd.wr && r_op == OP_REMOVE && !eq) begin
            we = 1'b1; waddr = r_wp[AW-1:0];
        end else if (i_cmd.fin && r_st == STS_OK && r_op == OP_INSERT) begin
            we = 1'b1; waddr = idx_w[AW-1:0]; wdata = r_val;
        end
    end

    olte_ram #(.W(DATA_W), .D(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // count after commit
    always_comb begin
        cnt_nx = r_cnt;
        rem    = '0;
        if (r_st == STS_OK) begin
            case (r_op)
                OP_INSERT, OP_PUSH: cnt_nx = r_cnt + CW'(1);
                OP_DELETE, OP_POP:  cnt_nx = r_cnt - CW'(1);
                OP_REMOVE: begin
                    cnt_nx = r_wp;
                    rem    = r_cnt - r_wp;
                end
                default: cnt_nx = r_cnt;
            endcase
        end
    end
    assign ncnt_w = IW'(cnt_nx);
    assign rem_w  = IW'(rem);
    assign fidx_w = IW'(r_fidx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_idx <= i_index;
            r_val <= i_value;
        end
        if (i_cmd.check) begin
            r_st    <= st_chk;
            r_rd    <= '0;
            r_found <= 1'b0;
            r_fidx  <= '0;
            r_wp    <= '0;
            case (r_op)
                OP_INSERT: r_ptr <= r_cnt;
                OP_POP:    r_ptr <= r_cnt - CW'(1);
                OP_GET, OP_DELETE: r_ptr <= CW'(idx_w);
                default:   r_ptr <= '0;
            endcase
        end
        if (i_cmd.wr) begin
            r_ptr <= ptr_nx;
            case (r_op)
                OP_GET, OP_POP: r_rd <= rdata;
                OP_FIND: if (eq) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_ptr;
                end
                OP_REMOVE: if (!eq) r_wp <= r_wp + CW'(1);
                default: r_wp <= r_wp;
            endcase
        end
        if (i_cmd.fin) begin
            r_o_rd    <= r_rd;
            r_o_found <= r_found;
            r_o_fidx  <= fidx_w[IDX_W-1:0];
            r_o_rem   <= rem_w[CNT_W-1:0];
            r_o_st    <= r_st;
            r_o_cnt   <= ncnt_w[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_cnt       <= cnt_nx;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.err      = err;
    assign o_sts.loop     = loop;
    assign o_sts.more     = more;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_o_rd;
    assign o_found         = r_o_found;
    assign o_found_index   = r_o_fidx;
    assign o_removed_count = r_o_rem;
    assign o_status        = r_o_st;
    assign o_element_count = r_o_cnt;
endmodule

// File: rtl/ordered_list_table_engine_unit.sv
// Top level of the ordered list table engine.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_op, i_index, i_value
//  out     | o_out_valid | i_out_stall | o_read_value, o_found, o_found_index,
//          |             |             | o_removed_count, o_status, o_element_count
//
// One item at a time. Set, push and any error go from check straight to commit;
// other items sweep N entries of the list memory between check and commit
// (get/pop: 1, insert: count-index, delete: count-index-1, find: up to count,
// remove_all: count). Each sweep step is a read, then a step that uses the read data.
// Reset (synchronous, active low) empties the list; the memory needs no clear.
// A stalled output holds the result; the next item may be taken meanwhile and
// waits at its commit step until the result register is free.
module ordered_list_table_engine_unit #(
    parameter int CAPACITY = olte_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [olte_pkg::OP_W-1:0]          i_op,
    input  logic [olte_pkg::IDX_W-1:0]         i_index,
    input  logic signed [olte_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [olte_pkg::DATA_W-1:0] o_read_value,
    output logic                               o_found,
    output logic [olte_pkg::IDX_W-1:0]         o_found_index,
    output logic [olte_pkg::CNT_W-1:0]         o_removed_count,
    output logic [olte_pkg::ST_W-1:0]          o_status,
    output logic [olte_pkg::CNT_W-1:0]         o_element_count
);
    import olte_pkg::*;

    t_cmd cmd;   // sequencer commands
    t_sts sts;   // datapath status

    olte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    olte_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_op),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_read_value    (o_read_value),
        .o_found         (o_found),
        .o_found_index   (o_found_index),
        .o_removed_count (o_removed_count),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );
endmodule
